>>> rtl/ctq_pkg.sv
// ----------------------------------------------------------------------------
// ctq_pkg
// Shared types and constants of the contact temperature qualifier.
// ----------------------------------------------------------------------------
package ctq_pkg;

    // Window length; the floor mean is an arithmetic shift, so this stays a
    // power of two.
    localparam int WIN_SIZE = 8;
    localparam int WIN_AW   = $clog2(WIN_SIZE);
    localparam int SUM_W    = 16 + WIN_AW;

    localparam logic signed [15:0] TEMP_MIN_RAW = -16'sd10240;
    localparam logic signed [15:0] TEMP_MAX_RAW = 16'sd32000;
    localparam logic [16:0]        ALPHA_ONE    = 17'd65536;

    // Configuration register indexes.
    localparam logic [2:0] CFG_ALPHA   = 3'd0;
    localparam logic [2:0] CFG_ON      = 3'd1;
    localparam logic [2:0] CFG_OFF     = 3'd2;
    localparam logic [2:0] CFG_OFFSET  = 3'd3;
    localparam logic [2:0] CFG_MIN_MS  = 3'd4;
    localparam logic [2:0] CFG_LIMIT   = 3'd5;
    localparam logic [2:0] CFG_RECOVER = 3'd6;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EVAL,
        S_SCAN,
        S_FIN,
        S_DONE
    } t_state;

endpackage

>>> rtl/ctq_in_if.sv
// ----------------------------------------------------------------------------
// ctq_in_if
// Sample channel: read-ok flag, raw temperature and timestamp.
// ----------------------------------------------------------------------------
interface ctq_in_if;
    logic               valid;
    logic               ready;
    logic               sample_ok;
    logic signed [15:0] raw_temp;
    logic [31:0]        now_ms;

    modport source (output valid, sample_ok, raw_temp, now_ms, input ready);
    modport sink   (input valid, sample_ok, raw_temp, now_ms, output ready);
endinterface

>>> rtl/ctq_out_if.sv
// ----------------------------------------------------------------------------
// ctq_out_if
// Result channel: qualification status and counters for one sample.
// ----------------------------------------------------------------------------
interface ctq_out_if;
    logic               valid;
    logic               ready;
    logic               temp_valid;
    logic               contact;
    logic               body_qualified;
    logic signed [16:0] body_temp;
    logic signed [15:0] stable_temp;
    logic [15:0]        stability_range;
    logic [31:0]        contact_time_ms;
    logic [31:0]        error_total;
    logic [31:0]        good_total;
    logic               recover_request;

    modport source (output valid, temp_valid, contact, body_qualified, body_temp,
                    stable_temp, stability_range, contact_time_ms,
                    error_total, good_total, recover_request, input ready);
    modport sink   (input valid, temp_valid, contact, body_qualified, body_temp,
                    stable_temp, stability_range, contact_time_ms,
                    error_total, good_total, recover_request, output ready);
endinterface

>>> rtl/contact_temperature_qualifier_unit.sv
// ----------------------------------------------------------------------------
// contact_temperature_qualifier_unit
// Qualifies skin contact temperature from raw sensor samples.
// ----------------------------------------------------------------------------
// Each sample yields one result transaction. A sample that fails or lies
// outside -40..125 degC, one that updates the baseline and one that does
// not complete the window pass from evaluation straight to delivery; one
// that completes the window first walks the window RAM, which gives one
// entry a cycle through a registered read, and then closes the walk in a
// finish state. A new sample is taken while a finished result still waits
// in the output register; the following result then waits until the
// output register is free.
module contact_temperature_qualifier_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [31:0] i_cfg_data,
    ctq_in_if.sink      i_in,
    ctq_out_if.source   o_out
);
    import ctq_pkg::*;

    // Configuration registers.
    logic [16:0]        r_alpha;
    logic [14:0]        r_on_delta, r_off_delta;
    logic signed [12:0] r_offset;
    logic [31:0]        r_min_ms;
    logic [15:0]        r_limit;
    logic [7:0]         r_recover;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_alpha     <= 17'd2621;
            r_on_delta  <= 15'd307;
            r_off_delta <= 15'd154;
            r_offset    <= 13'sd691;
            r_min_ms    <= 32'd8000;
            r_limit     <= 16'd46;
            r_recover   <= 8'd3;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_ALPHA:   r_alpha     <= i_cfg_data[16:0];
                CFG_ON:      r_on_delta  <= i_cfg_data[14:0];
                CFG_OFF:     r_off_delta <= i_cfg_data[14:0];
                CFG_OFFSET:  r_offset    <= $signed(i_cfg_data[12:0]);
                CFG_MIN_MS:  r_min_ms    <= i_cfg_data;
                CFG_LIMIT:   r_limit     <= i_cfg_data[15:0];
                CFG_RECOVER: r_recover   <= i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

    // Tracking state and registered sample.
    t_state              r_state, n_state;
    logic                r_ok;
    logic signed [15:0]  r_t;
    logic [31:0]         r_now;
    logic signed [31:0]  r_base, n_base;
    logic                r_contact, n_contact;
    logic [31:0]         r_start, n_start;
    logic [WIN_AW-1:0]   r_pos, n_pos;
    logic [WIN_AW:0]     r_fill, n_fill;
    logic                r_qual, n_qual;
    logic signed [15:0]  r_hstable, n_hstable;
    logic signed [16:0]  r_hbody, n_hbody;
    logic [15:0]         r_hrange, n_hrange;
    logic [31:0]         r_elapsed, n_elapsed;
    logic                r_last_ok, n_last_ok;
    logic [31:0]         r_errors, n_errors;
    logic [31:0]         r_goods, n_goods;
    logic [7:0]          r_err_run, n_err_run;
    logic [WIN_AW:0]     r_cnt, n_cnt;
    logic                r_rd_vld, n_rd_vld;
    logic signed [SUM_W-1:0] r_sum, n_sum;
    logic signed [15:0]  r_lo, n_lo, r_hi, n_hi;
    logic                r_out_vld, n_out_vld;

    // Window RAM port.
    logic                ram_we;
    logic [WIN_AW-1:0]   ram_addr;
    logic [15:0]         ram_rdata;

    ctq_ram #(.W(16), .D(WIN_SIZE)) u_win (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_addr  (ram_addr),
        .i_wdata (r_t),
        .o_rdata (ram_rdata)
    );

    logic slot_free;
    assign slot_free  = !r_out_vld || o_out.ready;
    assign i_in.ready = (r_state == S_IDLE);

    // Baseline arithmetic for the registered sample.
    logic signed [31:0] tq, base_eff;
    logic signed [32:0] delta;
    logic [16:0]        alpha_sat;
    logic signed [50:0] prod;
    logic signed [34:0] scaled;
    logic               in_range, on_hit, off_hit;
    logic signed [SUM_W-1:0] mean_w;
    logic signed [15:0] mean;
    logic signed [16:0] rng;

    always_comb begin
        tq        = {r_t, 16'd0};
        base_eff  = (r_base <= 0) ? tq : r_base;
        delta     = {tq[31], tq} - {base_eff[31], base_eff};
        alpha_sat = (r_alpha > ALPHA_ONE) ? ALPHA_ONE : r_alpha;
        prod      = delta * $signed({1'b0, alpha_sat});
        scaled    = prod[50:16];
        in_range  = r_ok && (r_t >= TEMP_MIN_RAW) && (r_t <= TEMP_MAX_RAW);
        on_hit    = delta >= $signed({2'b00, r_on_delta, 16'd0});
        off_hit   = delta < $signed({2'b00, r_off_delta, 16'd0});
        mean_w    = r_sum >>> WIN_AW;
        mean      = mean_w[15:0];
        rng       = {r_hi[15], r_hi} - {r_lo[15], r_lo};
    end

    // Sequencer: evaluate, walk the window, finish, deliver.
    always_comb begin
        n_state   = r_state;
        n_base    = r_base;
        n_contact = r_contact;
        n_start   = r_start;
        n_pos     = r_pos;
        n_fill    = r_fill;
        n_qual    = r_qual;
        n_hstable = r_hstable;
        n_hbody   = r_hbody;
        n_hrange  = r_hrange;
        n_elapsed = r_elapsed;
        n_last_ok = r_last_ok;
        n_errors  = r_errors;
        n_goods   = r_goods;
        n_err_run = r_err_run;
        n_cnt     = r_cnt;
        n_rd_vld  = 1'b0;
        n_sum     = r_sum;
        n_lo      = r_lo;
        n_hi      = r_hi;
        n_out_vld = r_out_vld && !o_out.ready;
        ram_we    = 1'b0;
        ram_addr  = r_pos;
        case (r_state)
            S_IDLE: begin
                if (i_in.valid && i_in.ready) begin
                    n_state = S_EVAL;
                end
            end
            S_EVAL: begin
                n_state = S_DONE;
                if (!in_range) begin
                    n_last_ok = 1'b0;
                    n_errors  = r_errors + 32'd1;
                    if (r_err_run != 8'hFF) begin
                        n_err_run = r_err_run + 8'd1;
                    end
                end else begin
                    n_last_ok = 1'b1;
                    n_err_run = 8'd0;
                    n_goods   = r_goods + 32'd1;
                    n_base    = base_eff;
                    if (!r_contact) begin
                        n_base    = base_eff + scaled[31:0];
                        n_qual    = 1'b0;
                        n_hbody   = '0;
                        n_hstable = '0;
                        n_elapsed = '0;
                        if (on_hit) begin
                            n_contact = 1'b1;
                            n_start   = r_now;
                            n_pos     = '0;
                            n_fill    = '0;
                            n_hrange  = '0;
                        end
                    end else begin
                        n_elapsed = r_now - r_start;
                        ram_we    = 1'b1;
                        n_pos     = r_pos + 1'b1;
                        if (r_fill != (WIN_AW+1)'(WIN_SIZE)) begin
                            n_fill = r_fill + 1'b1;
                        end
                        if (off_hit) begin
                            n_contact = 1'b0;
                            n_qual    = 1'b0;
                            n_hbody   = '0;
                            n_hstable = '0;
                            n_elapsed = '0;
                            n_pos     = '0;
                            n_fill    = '0;
                            n_hrange  = '0;
                        end else if (n_fill == (WIN_AW+1)'(WIN_SIZE)) begin
                            n_state = S_SCAN;
                            n_cnt   = '0;
                            n_sum   = '0;
                            n_lo    = 16'sh7FFF;
                            n_hi    = -16'sh8000;
                        end
                    end
                end
            end
            S_SCAN: begin
                // Issue one read a cycle, fold in the data of the last one.
                ram_addr = r_cnt[WIN_AW-1:0];
                if (r_cnt != (WIN_AW+1)'(WIN_SIZE)) begin
                    n_rd_vld = 1'b1;
                    n_cnt    = r_cnt + 1'b1;
                end
                if (r_rd_vld) begin
                    n_sum = r_sum + SUM_W'($signed(ram_rdata));
                    if ($signed(ram_rdata) < r_lo) n_lo = $signed(ram_rdata);
                    if ($signed(ram_rdata) > r_hi) n_hi = $signed(ram_rdata);
                end else if (r_cnt == (WIN_AW+1)'(WIN_SIZE)) begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                n_state  = S_DONE;
                n_hrange = rng[15:0];
                if (r_elapsed < r_min_ms || rng[15:0] > r_limit) begin
                    n_qual = 1'b0;
                end else begin
                    n_qual    = 1'b1;
                    n_hstable = mean;
                    n_hbody   = {mean[15], mean} + 17'(r_offset);
                end
            end
            S_DONE: begin
                if (slot_free) begin
                    n_out_vld = 1'b1;
                    n_state   = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_base    <= '0;
            r_contact <= 1'b0;
            r_start   <= '0;
            r_pos     <= '0;
            r_fill    <= '0;
            r_qual    <= 1'b0;
            r_hstable <= '0;
            r_hbody   <= '0;
            r_hrange  <= '0;
            r_elapsed <= '0;
            r_last_ok <= 1'b0;
            r_errors  <= '0;
            r_goods   <= '0;
            r_err_run <= '0;
            r_cnt     <= '0;
            r_rd_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_base    <= n_base;
            r_contact <= n_contact;
            r_start   <= n_start;
            r_pos     <= n_pos;
            r_fill    <= n_fill;
            r_qual    <= n_qual;
            r_hstable <= n_hstable;
            r_hbody   <= n_hbody;
            r_hrange  <= n_hrange;
            r_elapsed <= n_elapsed;
            r_last_ok <= n_last_ok;
            r_errors  <= n_errors;
            r_goods   <= n_goods;
            r_err_run <= n_err_run;
            r_cnt     <= n_cnt;
            r_rd_vld  <= n_rd_vld;
            r_out_vld <= n_out_vld;
        end
    end

    // Sample capture, window accumulators and the output register.
    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_ok  <= i_in.sample_ok;
            r_t   <= i_in.raw_temp;
            r_now <= i_in.now_ms;
        end
        r_sum <= n_sum;
        r_lo  <= n_lo;
        r_hi  <= n_hi;
        if (r_state == S_DONE && slot_free) begin
            o_out.temp_valid      <= r_last_ok;
            o_out.contact         <= r_contact;
            o_out.body_qualified  <= r_qual;
            o_out.body_temp       <= r_hbody;
            o_out.stable_temp     <= r_hstable;
            o_out.stability_range <= r_hrange;
            o_out.contact_time_ms <= r_elapsed;
            o_out.error_total     <= r_errors;
            o_out.good_total      <= r_goods;
            o_out.recover_request <= (r_err_run >= r_recover);
        end
    end

    assign o_out.valid = r_out_vld;
endmodule

>>> rtl/ctq_ram.sv
// ----------------------------------------------------------------------------
// ctq_ram
// Generic single-port RAM with a registered read.
// ----------------------------------------------------------------------------
module ctq_ram #(
    parameter int W = 16,
    parameter int D = 8
) (
    input  logic                 i_clk,
    input  logic                 i_we,
    input  logic [$clog2(D)-1:0] i_addr,
    input  logic [W-1:0]         i_wdata,
    output logic [W-1:0]         o_rdata
);
    logic [W-1:0] r_mem [D];
    logic [W-1:0] r_rdata;

    // Write and read one entry per cycle.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;
endmodule
